FILE: sv/hav_pkg.sv
package hav_pkg;

  parameter int DEG_FRAC_BITS_DEF = 16;

  localparam int N_TERMS   = 8;
  localparam int CELL_LAT  = 3;
  localparam int COS_LAT   = 7 + N_TERMS * CELL_LAT + 1;
  localparam int TOP_LAT   = 2 + COS_LAT + 3;

  localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
  localparam logic [31:0] HALF_Q30 = 32'h2000_0000;
  localparam logic [31:0] PI_Q30   = 32'hC90F_DAA2;

  // Horner beat handed from cell to cell
  typedef struct packed {
    logic        [31:0] x2;
    logic signed [31:0] t;
  } hav_beat_t;

  function automatic int coord_width(input int frac);
    return (frac + 11 > 27) ? frac + 11 : 27;
  endfunction

endpackage

FILE: sv/hav_cell.sv
module hav_cell
  import hav_pkg::*;
#(
  parameter int K = 1
) (
  input  logic      clk,
  input  hav_beat_t beat_in,
  output hav_beat_t beat_out
);

  localparam int          D  = (2 * K - 1) * (2 * K);
  localparam int          RK = 33;
  localparam logic [32:0] M  = 33'((64'd1 << RK) / D);

  logic        [31:0] ta;
  logic        [62:0] p_nxt;
  logic        [62:0] p_r;
  logic               s1_r;
  logic        [31:0] x2_1_r;

  logic        [31:0] q;
  logic        [64:0] qm;
  logic        [31:0] q_r;
  logic        [31:0] qe_r;
  logic               s2_r;
  logic        [31:0] x2_2_r;

  logic        [39:0] r;
  logic        [31:0] qf;
  logic signed [33:0] qs;
  logic signed [33:0] tn;
  hav_beat_t          out_r;

  always_comb begin
    ta    = beat_in.t[31] ? 32'(-beat_in.t) : 32'(beat_in.t);
    p_nxt = 63'(beat_in.x2) * 63'(ta[30:0]);
  end

  always_comb begin
    q  = p_r[61:30];
    qm = 65'(q) * 65'(M);
  end

  always_comb begin
    r  = 40'(q_r) - 40'(qe_r) * 40'(D);
    qf = (r >= 40'(D)) ? qe_r + 32'd1 : qe_r;
    qs = s2_r ? -34'(qf) : 34'(qf);
    tn = 34'(ONE_Q30) - qs;
  end

  always_ff @(posedge clk) begin
    p_r      <= p_nxt;
    s1_r     <= beat_in.t[31];
    x2_1_r   <= beat_in.x2;
    q_r      <= q;
    qe_r     <= qm[RK+31:RK];
    s2_r     <= s1_r;
    x2_2_r   <= x2_1_r;
    out_r.x2 <= x2_2_r;
    out_r.t  <= tn[31:0];
  end

  assign beat_out = out_r;

endmodule

FILE: sv/hav_cos.sv
module hav_cos
  import hav_pkg::*;
#(
  parameter int FRAC = DEG_FRAC_BITS_DEF,
  parameter int DW   = coord_width(DEG_FRAC_BITS_DEF)
) (
  input  logic                 clk,
  input  logic signed [DW-1:0] ang,
  output logic signed [31:0]   cos_q
);

  localparam int UW    = FRAC + 7;
  localparam int PW    = UW + 32;
  localparam int NEG_D = 6 + N_TERMS * CELL_LAT;
  localparam logic [DW-1:0] FULL    = DW'(360) << FRAC;
  localparam logic [DW-1:0] HALF    = DW'(180) << FRAC;
  localparam logic [DW-1:0] QUARTER = DW'(90) << FRAC;
  localparam logic [13:0] M1 = 14'((64'd1 << 21) / 180);
  localparam logic [21:0] M2 = 22'((64'd1 << 29) / 180);

  logic [DW-1:0] mag, f1, f2, f3;
  logic          neg;
  logic [UW-1:0] u_r;
  logic          neg_sr [0:NEG_D];

  logic [PW-1:0] prod_r;

  logic [38:0]   n;
  logic [32:0]   nhm;
  logic [18:0]   nh_r;
  logic [19:0]   nl_r;
  logic [11:0]   qhe_r;

  logic [18:0]   rh;
  logic [11:0]   qh_r;
  logic [7:0]    rh_r;
  logic [19:0]   nl2_r;

  logic [27:0]   m;
  logic [49:0]   mm;
  logic [27:0]   m_r;
  logic [20:0]   qle_r;
  logic [11:0]   qh2_r;

  logic [27:0]   rl;
  logic [20:0]   ql;
  logic [31:0]   x_nxt;
  logic [30:0]   x_r;

  logic [62:0]   xx;
  hav_beat_t     head_r;
  hav_beat_t     chain [0:N_TERMS];

  logic signed [31:0] tc;
  logic signed [31:0] cos_r;

  always_comb begin
    mag = ang[DW-1] ? DW'(-ang) : DW'(ang);
    f1  = (mag >= FULL) ? mag - FULL : mag;
    f2  = (f1 > HALF) ? FULL - f1 : f1;
    neg = f2 > QUARTER;
    f3  = neg ? HALF - f2 : f2;
  end

  always_comb begin
    n   = 39'(prod_r[PW-1:FRAC]) + 39'd90;
    nhm = 33'(n[38:20]) * 33'(M1);
  end

  always_comb begin
    rh = nh_r - 19'(qhe_r) * 19'd180;
  end

  always_comb begin
    m  = {rh_r, nl2_r};
    mm = 50'(m) * 50'(M2);
  end

  always_comb begin
    rl    = m_r - 28'(qle_r) * 28'd180;
    ql    = (rl >= 28'd180) ? qle_r + 21'd1 : qle_r;
    x_nxt = {qh2_r, 20'd0} + 32'(ql);
    xx    = 63'(x_r) * 63'(x_r) + 63'(HALF_Q30);
  end

  always_ff @(posedge clk) begin
    u_r       <= f3[UW-1:0];
    neg_sr[0] <= neg;
    for (int i = 1; i <= NEG_D; i++) begin
      neg_sr[i] <= neg_sr[i-1];
    end
    prod_r <= PW'(u_r) * PW'(PI_Q30);
    nh_r   <= n[38:20];
    nl_r   <= n[19:0];
    qhe_r  <= nhm[32:21];
    if (rh >= 19'd180) begin
      qh_r <= qhe_r + 12'd1;
      rh_r <= 8'(rh - 19'd180);
    end else begin
      qh_r <= qhe_r;
      rh_r <= rh[7:0];
    end
    nl2_r     <= nl_r;
    m_r       <= m;
    qle_r     <= mm[49:29];
    qh2_r     <= qh_r;
    x_r       <= x_nxt[30:0];
    head_r.x2 <= xx[61:30];
    head_r.t  <= signed'(ONE_Q30);
  end

  assign chain[0] = head_r;

  for (genvar g = 0; g < N_TERMS; g++) begin : g_cell
    hav_cell #(
      .K (N_TERMS - g)
    ) u_cell (
      .clk      (clk),
      .beat_in  (chain[g]),
      .beat_out (chain[g+1])
    );
  end

  always_comb begin
    tc = chain[N_TERMS].t;
    if (tc < 0) begin
      tc = '0;
    end else if (tc > signed'(ONE_Q30)) begin
      tc = signed'(ONE_Q30);
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= neg_sr[NEG_D] ? -tc : tc;
  end

  assign cos_q = cos_r;

endmodule

FILE: sv/haversine_term_from_degrees.sv
// Haversine term of two geographic points.
// Input: pulse start with in_lat_a, in_lon_a, in_lat_b, in_lon_b, signed
// degrees with DEG_FRAC_BITS fraction bits; the beat is taken at any edge
// where start is high and busy is low. busy stays low, so a new pair may be
// given every cycle.
// Output: out_valid is high for one cycle with out_hav_term, unsigned Q1.30,
// saturated at one. Coordinates beyond +/-90 and +/-180 degrees are clamped.
// Throughput is one beat per cycle: each cosine runs down a row of eight
// Horner cells, three stages each, behind a seven-stage fold and radian
// conversion.
// Reset clears the valid pipeline only; beats in flight are dropped.
// The receiver cannot stall; results are never held back.
module haversine_term_from_degrees
  import hav_pkg::*;
#(
  parameter int DEG_FRAC_BITS = DEG_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] in_lat_a,
  input  logic signed [24:0] in_lon_a,
  input  logic signed [23:0] in_lat_b,
  input  logic signed [24:0] in_lon_b,
  output logic               out_valid,
  output logic        [30:0] out_hav_term
);

  localparam int DW = coord_width(DEG_FRAC_BITS);
  localparam logic signed [DW-1:0] LAT_LIM = DW'(90) << DEG_FRAC_BITS;
  localparam logic signed [DW-1:0] LON_LIM = DW'(180) << DEG_FRAC_BITS;

  logic signed [DW-1:0] la_x, oa_x, lb_x, ob_x;
  logic signed [DW-1:0] la_r, oa_r, lb_r, ob_r;
  logic signed [DW-1:0] la2_r, lb2_r, dlat_r, dlon_r;
  logic signed [31:0]   c_dlat, c_dlon, c_a, c_b;

  logic        [32:0]   hl_w, ho_w;
  logic        [62:0]   ab_w;
  logic        [30:0]   hlat_r, hlon_r, mab_r, hlat2_r, m2_r;
  logic        [61:0]   m2_w;
  logic        [31:0]   sum;
  logic        [30:0]   out_r;
  logic        [TOP_LAT-1:0] vld_r;

  function automatic logic signed [DW-1:0] clamp(input logic signed [DW-1:0] v,
                                                 input logic signed [DW-1:0] lim);
    if (v > lim) begin
      return lim;
    end else if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  assign busy = 1'b0;

  always_comb begin
    la_x = clamp(DW'(in_lat_a), LAT_LIM);
    oa_x = clamp(DW'(in_lon_a), LON_LIM);
    lb_x = clamp(DW'(in_lat_b), LAT_LIM);
    ob_x = clamp(DW'(in_lon_b), LON_LIM);
  end

  always_ff @(posedge clk) begin
    la_r   <= la_x;
    oa_r   <= oa_x;
    lb_r   <= lb_x;
    ob_r   <= ob_x;
    la2_r  <= la_r;
    lb2_r  <= lb_r;
    dlat_r <= lb_r - la_r;
    dlon_r <= ob_r - oa_r;
  end

  hav_cos #(.FRAC(DEG_FRAC_BITS), .DW(DW)) u_cos_dlat (
    .clk(clk), .ang(dlat_r), .cos_q(c_dlat));
  hav_cos #(.FRAC(DEG_FRAC_BITS), .DW(DW)) u_cos_dlon (
    .clk(clk), .ang(dlon_r), .cos_q(c_dlon));
  hav_cos #(.FRAC(DEG_FRAC_BITS), .DW(DW)) u_cos_a (
    .clk(clk), .ang(la2_r), .cos_q(c_a));
  hav_cos #(.FRAC(DEG_FRAC_BITS), .DW(DW)) u_cos_b (
    .clk(clk), .ang(lb2_r), .cos_q(c_b));

  always_comb begin
    hl_w = (33'(ONE_Q30) + 33'd1 - 33'(c_dlat)) >> 1;
    ho_w = (33'(ONE_Q30) + 33'd1 - 33'(c_dlon)) >> 1;
    ab_w = 63'(c_a[30:0]) * 63'(c_b[30:0]) + 63'(HALF_Q30);
    m2_w = 62'(mab_r) * 62'(hlon_r) + 62'(HALF_Q30);
    sum  = 32'(hlat2_r) + 32'(m2_r);
  end

  always_ff @(posedge clk) begin
    hlat_r  <= hl_w[30:0];
    hlon_r  <= ho_w[30:0];
    mab_r   <= ab_w[60:30];
    hlat2_r <= hlat_r;
    m2_r    <= m2_w[60:30];
    out_r   <= (sum > 32'(ONE_Q30)) ? ONE_Q30[30:0] : sum[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[TOP_LAT-2:0], start & ~busy};
    end
  end

  assign out_valid    = vld_r[TOP_LAT-1];
  assign out_hav_term = out_r;

endmodule

FILE: sv/hav_chk.sv
module hav_chk
  import hav_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [23:0] in_lat_a,
  input logic [24:0] in_lon_a,
  input logic [23:0] in_lat_b,
  input logic [24:0] in_lon_b,
  input logic        out_valid,
  input logic [30:0] out_hav_term
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##TOP_LAT out_valid)
    else $error("beat not delivered after pipeline latency");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hav_term <= 31'(ONE_Q30))
    else $error("result above one");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("strobe after reset");

  a_same_point: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_lat_a == in_lat_b && in_lon_a == in_lon_b
    |-> ##TOP_LAT out_hav_term == '0)
    else $error("coincident points give nonzero term");

endmodule

bind haversine_term_from_degrees hav_chk u_hav_chk (.*);
